// File: hdl/rgb_to_hsl_converter_defines.svh
// Assertion macros used by the checker of the RGB to HSL converter
`ifndef RGB_TO_HSL_CONVERTER_DEFINES_SVH
`define RGB_TO_HSL_CONVERTER_DEFINES_SVH

// Same-cycle implication, sampled on clk, off while arst_n is low
`define RHSL_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk, off while arst_n is low
`define RHSL_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hdl/rhsl_pkg.sv
// Types and constants shared by the RGB to HSL converter
package rhsl_pkg;

	// Field widths
	localparam int unsigned CH_W   = 8;
	localparam int unsigned HUE_W  = 15;
	localparam int unsigned FRAC_W = 16;

	// Hue in 1/64 degree
	localparam logic [HUE_W-1:0] HUE_FULL       = 15'd23040;
	localparam logic [HUE_W-1:0] HUE_THIRD      = 15'd7680;
	localparam logic [HUE_W-1:0] HUE_TWO_THIRDS = 15'd15360;

	// Hue sector, picked by the channel that holds the maximum
	localparam logic [1:0] SEC_RED   = 2'd0;
	localparam logic [1:0] SEC_GREEN = 2'd1;
	localparam logic [1:0] SEC_BLUE  = 2'd2;

	// Long division: one quotient bit per stage, 8-bit divisors
	localparam int unsigned DIV_QW     = 16;
	localparam int unsigned DIV_NW     = DIV_QW + CH_W;
	localparam int unsigned DIV_LANES  = 2;
	localparam int unsigned LANE_HUE   = 0;
	localparam int unsigned LANE_SAT   = 1;

	// Lightness 16384*(M+m)/255 as (M+m)*ceil(2^31/255) >> 17, exact for M+m <= 510
	localparam int unsigned          RECIP_W     = 24;
	localparam logic [RECIP_W-1:0]   LIGHT_RECIP = 24'd8421505;
	localparam int unsigned          LIGHT_SHIFT = 17;

	// Hue numerator is 15*|diff| (12 bits), scaled by 256 before division
	localparam int unsigned HNUM_W = 12;

	// Register stages ahead of the output register
	localparam int unsigned PIPE_STAGES = 2 + DIV_QW;

	typedef struct packed {
		logic [CH_W-1:0] red;
		logic [CH_W-1:0] green;
		logic [CH_W-1:0] blue;
	} rgb_t;

	typedef struct packed {
		logic [HUE_W-1:0]  hue;
		logic [FRAC_W-1:0] saturation;
		logic [FRAC_W-1:0] lightness;
	} hsl_t;

	// Per-pixel flags and the finished lightness that ride alongside the divider
	typedef struct packed {
		logic [1:0]        sec;
		logic              neg;
		logic              grey;
		logic [FRAC_W-1:0] light;
	} side_t;

	// Front-end result handed to the divider
	typedef struct packed {
		logic [HNUM_W-1:0] hnum;
		logic [CH_W-1:0]   chroma;
		logic [CH_W-1:0]   den;
		side_t             side;
	} front_t;

endpackage

// File: hdl/rhsl_front.sv
// Front end: max/min, sector, chroma, lightness and the division operands
module rhsl_front import rhsl_pkg::*; (
	input  logic   clk,
	input  logic   adv,
	input  rgb_t   pix,
	output front_t fr
);

	logic [CH_W-1:0] hi;
	logic [CH_W-1:0] lo;
	logic [1:0]      sec;
	logic [CH_W:0]   diff;

	logic [1:0]      sec_s1;
	logic [CH_W:0]   diff_s1;
	logic [CH_W-1:0] chroma_s1;
	logic [CH_W:0]   sum_s1;

	logic [CH_W:0]   mag;
	logic [CH_W:0]   den_w;
	logic [CH_W+RECIP_W:0] light_prod;
	front_t          fr_nxt;
	front_t          fr_s2;

	// Largest and smallest channel, sector and signed difference
	always_comb begin
		hi = pix.red;
		lo = pix.red;
		if (pix.green > hi) hi = pix.green;
		if (pix.blue > hi) hi = pix.blue;
		if (pix.green < lo) lo = pix.green;
		if (pix.blue < lo) lo = pix.blue;
		if (hi == pix.red) begin
			sec  = SEC_RED;
			diff = {1'b0, pix.green} - {1'b0, pix.blue};
		end else if (hi == pix.green) begin
			sec  = SEC_GREEN;
			diff = {1'b0, pix.blue} - {1'b0, pix.red};
		end else begin
			sec  = SEC_BLUE;
			diff = {1'b0, pix.red} - {1'b0, pix.green};
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			sec_s1    <= sec;
			diff_s1   <= diff;
			chroma_s1 <= hi - lo;
			sum_s1    <= {1'b0, hi} + {1'b0, lo};
		end
	end

	// Magnitude of the difference, saturation divisor, hue numerator 15*|diff|,
	// lightness by reciprocal multiply
	always_comb begin
		mag   = diff_s1[CH_W] ? ((CH_W+1)'(0) - diff_s1) : diff_s1;
		den_w = (sum_s1 > 9'd255) ? (9'd510 - sum_s1) : sum_s1;
		light_prod = {(RECIP_W)'(0), sum_s1} * {(CH_W+1)'(0), LIGHT_RECIP};
		fr_nxt.hnum       = {mag[CH_W-1:0], 4'd0} - {4'd0, mag[CH_W-1:0]};
		fr_nxt.chroma     = chroma_s1;
		fr_nxt.den        = den_w[CH_W-1:0];
		fr_nxt.side.sec   = sec_s1;
		fr_nxt.side.neg   = diff_s1[CH_W];
		fr_nxt.side.grey  = (chroma_s1 == '0);
		fr_nxt.side.light = light_prod[LIGHT_SHIFT +: FRAC_W];
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			fr_s2 <= fr_nxt;
		end
	end

	assign fr = fr_s2;

endmodule

// File: hdl/rhsl_div.sv
// Pipelined restoring divider: several lanes, one quotient bit per stage
module rhsl_div import rhsl_pkg::*; #(
	parameter int unsigned LANES = DIV_LANES,
	parameter int unsigned QW    = DIV_QW,
	parameter int unsigned DW    = CH_W,
	parameter int unsigned SW    = $bits(side_t)
) (
	input  logic                clk,
	input  logic                adv,
	input  logic [QW+DW-1:0]    num      [LANES],
	input  logic [DW-1:0]       den      [LANES],
	input  logic [SW-1:0]       side_in,
	output logic [QW-1:0]       quo      [LANES],
	output logic [DW-1:0]       rem      [LANES],
	output logic [SW-1:0]       side_out
);

	localparam int unsigned NW = QW + DW;

	// Stage registers, index is the stage
	logic [DW-1:0] rem_s  [QW][LANES];
	logic [QW-1:0] low_s  [QW][LANES];
	logic [QW-1:0] quo_s  [QW][LANES];
	logic [DW-1:0] den_s  [QW][LANES];
	logic [SW-1:0] side_s [QW];

	genvar k, l;
	generate
		for (k = 0; k < QW; k++) begin : g_stage
			// Flags travel with the operands
			if (k == 0) begin : g_side_first
				always_ff @(posedge clk) begin
					if (adv) side_s[k] <= side_in;
				end
			end else begin : g_side_next
				always_ff @(posedge clk) begin
					if (adv) side_s[k] <= side_s[k-1];
				end
			end

			for (l = 0; l < LANES; l++) begin : g_lane
				logic [DW-1:0] src_rem;
				logic [QW-1:0] src_low;
				logic [QW-1:0] src_quo;
				logic [DW-1:0] src_den;
				logic [DW:0]   part;
				logic          ge;

				if (k == 0) begin : g_first
					assign src_rem = num[l][NW-1:QW];
					assign src_low = num[l][QW-1:0];
					assign src_quo = '0;
					assign src_den = den[l];
				end else begin : g_next
					assign src_rem = rem_s[k-1][l];
					assign src_low = low_s[k-1][l];
					assign src_quo = quo_s[k-1][l];
					assign src_den = den_s[k-1][l];
				end

				// Bring down the next numerator bit, subtract if it fits
				assign part = {src_rem, src_low[QW-1]};
				assign ge   = (part >= {1'b0, src_den});

				always_ff @(posedge clk) begin
					if (adv) begin
						rem_s[k][l] <= ge ? DW'(part - {1'b0, src_den}) : part[DW-1:0];
						low_s[k][l] <= src_low << 1;
						quo_s[k][l] <= (src_quo << 1) | QW'(ge);
						den_s[k][l] <= src_den;
					end
				end
			end
		end

		for (l = 0; l < LANES; l++) begin : g_out
			assign quo[l] = quo_s[QW-1][l];
			assign rem[l] = rem_s[QW-1][l];
		end
	endgenerate

	assign side_out = side_s[QW-1];

endmodule

// File: hdl/rhsl_flow.sv
// Valid chain of the pipeline, output register and skid buffer
module rhsl_flow import rhsl_pkg::*; #(
	parameter int unsigned NST = PIPE_STAGES
) (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic adv,
	input  hsl_t res,
	output logic hsl_valid,
	input  logic hsl_ready,
	output hsl_t hsl
);

	logic [NST-1:0] vld_q;
	logic           out_v_q;
	logic           skid_v_q;
	hsl_t           out_q;
	hsl_t           skid_q;
	logic           take;
	logic           pipe_v;

	// Pipeline moves as a whole while the skid stage is empty
	assign adv    = ~skid_v_q;
	assign pipe_v = vld_q[NST-1] & adv;
	assign take   = hsl_ready | ~out_v_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (adv) begin
			vld_q <= {vld_q[NST-2:0], pix_valid};
		end
	end

	// Output and skid occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q  <= 1'b0;
			skid_v_q <= 1'b0;
		end else if (take) begin
			out_v_q  <= skid_v_q | pipe_v;
			skid_v_q <= 1'b0;
		end else if (pipe_v) begin
			skid_v_q <= 1'b1;
		end
	end

	// Beat payloads
	always_ff @(posedge clk) begin
		if (take) begin
			out_q <= skid_v_q ? skid_q : res;
		end else if (pipe_v) begin
			skid_q <= res;
		end
	end

	assign hsl_valid = out_v_q;
	assign hsl       = out_q;

endmodule

// File: hdl/rgb_to_hsl_converter.sv
// Top level of the RGB to HSL converter
//
// Takes one 8-bit RGB pixel per beat on the pix channel and returns hue
// (1/64 degree), saturation and lightness (1.15 format) on the hsl channel.
// Both channels use valid/ready; a beat moves when both are high.
// Throughput: one pixel per cycle while the skid stage is empty. The 16 stages
// of the bit-per-stage long divider (two lanes: hue and saturation) set the
// depth; two front stages find max, min, chroma, the operands and the
// lightness, which is a reciprocal multiply and rides with the divider's flags.
// Grey pixels give hue and saturation of zero.
// Reset clears the valid chain, the output and the skid stage; no pixel
// is in flight afterwards and pix_ready comes up high.
// When the receiver stalls, the pipeline keeps moving until one more
// result sits in the skid stage, then pix_ready drops and everything
// holds; nothing is lost or repeated.
module rgb_to_hsl_converter import rhsl_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic pix_valid,
	output logic pix_ready,
	input  rgb_t pix,
	output logic hsl_valid,
	input  logic hsl_ready,
	output hsl_t hsl
);

	logic                adv;
	front_t              fr;
	logic [DIV_NW-1:0]   num  [DIV_LANES];
	logic [CH_W-1:0]     den  [DIV_LANES];
	logic [DIV_QW-1:0]   quo  [DIV_LANES];
	logic [CH_W-1:0]     rem  [DIV_LANES];
	logic [$bits(side_t)-1:0] side_bits;
	side_t               side;
	hsl_t                res;

	logic [HNUM_W-1:0]   qh;
	logic [HNUM_W:0]     ceilq;
	logic [HUE_W-1:0]    base;

	rhsl_front u_front (
		.clk (clk),
		.adv (adv),
		.pix (pix),
		.fr  (fr)
	);

	// Dividends are scaled so that each quotient is the wanted fixed point
	assign num[LANE_HUE]   = DIV_NW'({fr.hnum, 8'd0});
	assign num[LANE_SAT]   = DIV_NW'({fr.chroma, 15'd0});
	assign den[LANE_HUE]   = fr.chroma;
	assign den[LANE_SAT]   = fr.den;

	rhsl_div #(
		.LANES (DIV_LANES),
		.QW    (DIV_QW),
		.DW    (CH_W),
		.SW    ($bits(side_t))
	) u_div (
		.clk      (clk),
		.adv      (adv),
		.num      (num),
		.den      (den),
		.side_in  (fr.side),
		.quo      (quo),
		.rem      (rem),
		.side_out (side_bits)
	);

	assign side = side_t'(side_bits);

	// Hue: floor for a positive offset, negated ceiling for a negative one
	always_comb begin
		qh    = quo[LANE_HUE][HNUM_W-1:0];
		ceilq = {1'b0, qh} + (HNUM_W+1)'(rem[LANE_HUE] != '0);
		case (side.sec)
			SEC_RED:   base = side.neg ? HUE_FULL : '0;
			SEC_GREEN: base = HUE_THIRD;
			SEC_BLUE:  base = HUE_TWO_THIRDS;
			default:   base = HUE_TWO_THIRDS;
		endcase
		if (side.grey) begin
			res.hue = '0;
		end else if (side.neg) begin
			res.hue = base - HUE_W'(ceilq);
		end else begin
			res.hue = base + HUE_W'(qh);
		end
		res.saturation = side.grey ? '0 : quo[LANE_SAT];
		res.lightness  = side.light;
	end

	rhsl_flow #(
		.NST (PIPE_STAGES)
	) u_flow (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.adv       (adv),
		.res       (res),
		.hsl_valid (hsl_valid),
		.hsl_ready (hsl_ready),
		.hsl       (hsl)
	);

	assign pix_ready = adv;

endmodule

// File: hdl/rhsl_checker.sv
// Port-level checks for the RGB to HSL converter, bound to the top level
`include "rgb_to_hsl_converter_defines.svh"

module rhsl_checker import rhsl_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic pix_valid,
	input logic pix_ready,
	input rgb_t pix,
	input logic hsl_valid,
	input logic hsl_ready,
	input hsl_t hsl
);

	logic in_stall;
	logic out_stall;
	logic in_range;
	logic sat_zero;

	// Terms used by the checks below
	assign in_stall  = pix_valid && !pix_ready;
	assign out_stall = hsl_valid && !hsl_ready;
	assign in_range  = (hsl.hue < HUE_FULL) && (hsl.saturation <= 16'd32768) &&
		(hsl.lightness <= 16'd32768);
	assign sat_zero  = hsl_valid && (hsl.saturation == '0);

	// A stalled pixel beat holds
	`RHSL_ASSERT_NEXT(a_pix_hold, in_stall, pix_valid && $stable(pix), "stalled pixel changed")

	// A stalled result beat holds
	`RHSL_ASSERT_NEXT(a_hold, out_stall, hsl_valid && $stable(hsl), "stalled beat changed")

	// Results stay inside their ranges
	`RHSL_ASSERT_NOW(a_range, hsl_valid, in_range, "result out of range")

	// Zero saturation only for grey pixels, which have zero hue
	`RHSL_ASSERT_NOW(a_grey, sat_zero, hsl.hue == '0, "grey pixel with nonzero hue")

	// Input back-pressure only while a result waits at the output
	`RHSL_ASSERT_NOW(a_stall, !pix_ready, hsl_valid, "input stalled with empty output")

endmodule

bind rgb_to_hsl_converter rhsl_checker u_rhsl_checker (.*);

// File: verif/rgb_to_hsl_converter_tb.sv
// Self-checking testbench for the RGB to HSL converter: directed and random pixels
`timescale 1ns / 1ps

module rgb_to_hsl_converter_tb;
	import rhsl_pkg::*;

	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 300;
	localparam int RANDOM_PER_PH = 382;
	localparam int DRAIN_CYCLES  = 40;
	localparam int HUE_SIXTH     = 3840;

	// One pixel in flight and the HSL result it should produce
	typedef struct {
		rgb_t pix;
		hsl_t want;
	} hsl_entry_t;

	// Works out HSL for each accepted pixel and checks results in order
	class hsl_scoreboard;
		hsl_entry_t pending[$];
		int         noted;
		int         compared;
		int         errors;

		function new();
			noted    = 0;
			compared = 0;
			errors   = 0;
		endfunction

		// floor of num/den for den > 0
		function int div_floor(int num, int den);
			if (num >= 0) begin
				return num / den;
			end
			return -((-num + den - 1) / den);
		endfunction

		function hsl_t convert_pixel(rgb_t p);
			int   r, g, b, hi, lo, chroma, sum, den, h;
			hsl_t res;
			r = p.red;
			g = p.green;
			b = p.blue;
			hi = r;
			lo = r;
			if (g > hi) hi = g;
			if (b > hi) hi = b;
			if (g < lo) lo = g;
			if (b < lo) lo = b;
			chroma = hi - lo;
			sum    = hi + lo;
			res.lightness = FRAC_W'((32768 * sum) / 510);
			if (chroma == 0) begin
				// grey: no hue, no saturation
				res.hue        = '0;
				res.saturation = '0;
			end else begin
				// sector goes to the first channel holding the maximum: red, green, blue
				if (hi == r) begin
					h = div_floor(HUE_SIXTH * (g - b), chroma);
					if (h < 0) h += int'(HUE_FULL);
				end else if (hi == g) begin
					h = int'(HUE_THIRD) + div_floor(HUE_SIXTH * (b - r), chroma);
				end else begin
					h = int'(HUE_TWO_THIRDS) + div_floor(HUE_SIXTH * (r - g), chroma);
				end
				den = (sum > 255) ? (510 - sum) : sum;
				res.hue        = HUE_W'(h);
				res.saturation = FRAC_W'((32768 * chroma) / den);
			end
			return res;
		endfunction

		function void note_pixel(rgb_t p);
			hsl_entry_t e;
			e.pix  = p;
			e.want = convert_pixel(p);
			pending.push_back(e);
			noted++;
		endfunction

		function void check_hsl(hsl_t got);
			hsl_entry_t e;
			if (pending.size() == 0) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: hsl beat with no pixel pending: hue %0d sat %0d light %0d",
						got.hue, got.saturation, got.lightness);
				return;
			end
			e = pending.pop_front();
			compared++;
			if (got.hue !== e.want.hue || got.saturation !== e.want.saturation ||
					got.lightness !== e.want.lightness) begin
				errors++;
				if (errors <= 10)
					$display("ERROR: rgb %0d,%0d,%0d: exp h/s/l %0d/%0d/%0d got %0d/%0d/%0d",
						e.pix.red, e.pix.green, e.pix.blue,
						e.want.hue, e.want.saturation, e.want.lightness,
						got.hue, got.saturation, got.lightness);
			end
		endfunction
	endclass

	logic clk       = 1'b0;
	logic arst_n    = 1'b0;
	logic pix_valid = 1'b0;
	logic pix_ready;
	rgb_t pix       = '0;
	logic hsl_valid;
	logic hsl_ready = 1'b0;
	hsl_t hsl;

	hsl_scoreboard sb;
	int cycles          = 0;
	int sender_idle_pct = 0;
	int recv_stall_pct  = 0;
	int hold_requests   = 0;
	int holds_served    = 0;
	int hold_left       = 0;

	rgb_to_hsl_converter uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pix_valid (pix_valid),
		.pix_ready (pix_ready),
		.pix       (pix),
		.hsl_valid (hsl_valid),
		.hsl_ready (hsl_ready),
		.hsl       (hsl)
	);

	always #1 clk = ~clk;

	// Watchdog
	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Timeout after %0d cycles, %0d results outstanding",
				cycles, sb.pending.size());
			$display("FAILED: results differ");
			$finish;
		end
	end

	// Output side: take beats, stall at random, long hold-off on request
	always @(posedge clk) begin
		if (arst_n) begin
			if (hsl_valid && hsl_ready)
				sb.check_hsl(hsl);
			if (hold_requests != holds_served) begin
				holds_served++;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				hold_left--;
				hsl_ready <= 1'b0;
			end else begin
				hsl_ready <= !($urandom_range(0, 99) < recv_stall_pct);
			end
		end
	end

	// Offer one pixel, with random idle cycles ahead of it
	task automatic send_pixel(input rgb_t p);
		while ($urandom_range(0, 99) < sender_idle_pct) begin
			pix_valid <= 1'b0;
			@(posedge clk);
		end
		pix       <= p;
		pix_valid <= 1'b1;
		do @(posedge clk); while (!pix_ready);
		sb.note_pixel(p);
	endtask

	// Uniform for half the draws, with greys, ties, extreme channels and small chroma in the rest
	function automatic rgb_t random_pixel();
		rgb_t p;
		int   base;
		p.red   = 8'($urandom);
		p.green = 8'($urandom);
		p.blue  = 8'($urandom);
		case ($urandom_range(0, 11))
			0: begin
				p.green = p.red;
				p.blue  = p.red;
			end
			1: p.green = p.red;
			2: p.blue = p.green;
			3: p.blue = p.red;
			4: begin
				p.red   = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.green = $urandom_range(0, 1) ? 8'hFF : 8'h00;
				p.blue  = $urandom_range(0, 1) ? 8'hFE : 8'h01;
			end
			5: begin
				base    = $urandom_range(0, 250);
				p.red   = 8'(base + $urandom_range(0, 5));
				p.green = 8'(base + $urandom_range(0, 5));
				p.blue  = 8'(base + $urandom_range(0, 5));
			end
			default: ;
		endcase
		return p;
	endfunction

	// Stimulus
	initial begin
		sb = new();
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: black, white, greys, primaries, ties, hue wrap, lightness boundary
		send_pixel({8'd0,   8'd0,   8'd0});
		send_pixel({8'd255, 8'd255, 8'd255});
		send_pixel({8'd128, 8'd128, 8'd128});
		send_pixel({8'd1,   8'd1,   8'd1});
		send_pixel({8'd255, 8'd0,   8'd0});
		send_pixel({8'd0,   8'd255, 8'd0});
		send_pixel({8'd0,   8'd0,   8'd255});
		send_pixel({8'd255, 8'd255, 8'd0});
		send_pixel({8'd0,   8'd255, 8'd255});
		send_pixel({8'd255, 8'd0,   8'd255});
		send_pixel({8'd255, 8'd0,   8'd1});
		send_pixel({8'd1,   8'd0,   8'd0});
		send_pixel({8'd0,   8'd1,   8'd0});
		send_pixel({8'd0,   8'd0,   8'd1});
		send_pixel({8'd255, 8'd1,   8'd0});
		send_pixel({8'd128, 8'd127, 8'd127});
		send_pixel({8'd128, 8'd128, 8'd127});
		send_pixel({8'd20,  8'd255, 8'd10});
		send_pixel({8'd10,  8'd20,  8'd255});
		send_pixel({8'hAA,  8'h55,  8'hAA});
		send_pixel({8'h55,  8'hAA,  8'h55});
		send_pixel({8'd254, 8'd255, 8'd255});

		// Random, through the idling phases
		for (int ph = 0; ph < 4; ph++) begin
			case (ph)
				0: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 0;
					// fill the pipe against a held output
					hold_requests++;
				end
				1: begin
					sender_idle_pct = 87;
					recv_stall_pct  = 0;
				end
				2: begin
					sender_idle_pct = 0;
					recv_stall_pct  = 87;
				end
				default: begin
					sender_idle_pct = 17;
					recv_stall_pct  = 17;
				end
			endcase
			for (int i = 0; i < RANDOM_PER_PH; i++)
				send_pixel(random_pixel());
		end

		pix_valid <= 1'b0;
		sender_idle_pct = 0;
		recv_stall_pct  = 0;
		while (sb.pending.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("Sent %0d pixels: extremes, greys, tied maxima, hue wrap and random colours",
			sb.noted);
		$display("Checked %0d results over four idling phases and a %0d-cycle output hold-off",
			sb.compared, HOLD_CYCLES);
		if (sb.errors == 0 && sb.pending.size() == 0) begin
			$display("PASSED: all results match");
		end else begin
			$display("%0d errors, %0d results missing", sb.errors, sb.pending.size());
			$display("FAILED: results differ");
		end
		$finish;
	end

endmodule

// File: sim.f
+incdir+hdl
hdl/rhsl_pkg.sv
hdl/rhsl_front.sv
hdl/rhsl_div.sv
hdl/rhsl_flow.sv
hdl/rgb_to_hsl_converter.sv
hdl/rhsl_checker.sv
verif/rgb_to_hsl_converter_tb.sv
